>>> src/rmj_pkg.sv
package rmj_pkg;

    localparam int MUL_LIMB = 32;
    localparam int THR_BITS = 16;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd7;

endpackage

>>> src/rmj_if.sv
interface rmj_state_if #(parameter int WORD_BITS = 32) ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] vel_x;
    logic signed [WORD_BITS-1:0] vel_y;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rmj_jac_if #(parameter int WORD_BITS = 32) ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] range_dx;
    logic signed [WORD_BITS-1:0] range_dy;
    logic signed [WORD_BITS-1:0] bearing_dx;
    logic signed [WORD_BITS-1:0] bearing_dy;
    logic signed [WORD_BITS-1:0] rate_dx;
    logic signed [WORD_BITS-1:0] rate_dy;
    logic                        too_close;

    modport source (output valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx,
                    rate_dy, too_close, input ready);
    modport sink (input valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx,
                  rate_dy, too_close, output ready);
endinterface

interface rmj_cfg_if import rmj_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [THR_BITS-1:0] zero_threshold;

    modport source (output valid, zero_threshold, input ready);
    modport sink (input valid, zero_threshold, output ready);
endinterface

>>> src/radar_measurement_jacobian.sv
// Throughput: one beat per cycle unless the pipeline holds; the square-root row
// (WORD_BITS cells) and six divider rows (WORD_BITS cells each) advance with it.
// The pipeline holds only when its last stage and the output register are both
// full and the output is not ready.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets zero_threshold to 7.
module radar_measurement_jacobian import rmj_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmj_state_if.sink    i_state,
    rmj_jac_if.source    o_jac,
    rmj_cfg_if.sink      i_cfg
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int P  = 2 * W + 10;
    localparam int TW = 2 * W + THR_BITS + F;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] raw);
        return raw[W-1] ? (~raw + 1'b1) : raw;
    endfunction

    function automatic logic [W-1:0] finish(input logic [W-1:0] q, input logic ovf,
                                            input logic neg);
        logic [W-1:0] lim;
        logic [W-1:0] qs;
        lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        qs  = (ovf || q > lim) ? lim : q;
        return neg ? (~qs + 1'b1) : qs;
    endfunction

    // control
    logic                r_ov;
    logic [P:1]          r_vld;
    logic [THR_BITS-1:0] r_thr;
    logic                en;
    logic                acc;
    logic                out_load;

    assign en            = !(r_vld[P] && r_ov && !o_jac.ready);
    assign acc           = i_state.valid && en;
    assign out_load      = !r_ov || o_jac.ready;
    assign i_state.ready = en;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_vld <= '0;
            r_thr <= THR_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_thr <= i_cfg.zero_threshold;
            end
            if (en) begin
                r_vld <= {r_vld[P-1:1], acc};
            end
            if (out_load) begin
                r_ov <= r_vld[P];
            end
        end
    end

    // stage 1: sign and magnitude
    logic [W-1:0] r1_mx, r1_my, r1_mvx, r1_mvy;
    logic         r1_nx, r1_ny, r1_nvx, r1_nvy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mx  <= mag_of(i_state.pos_x);
            r1_my  <= mag_of(i_state.pos_y);
            r1_mvx <= mag_of(i_state.vel_x);
            r1_mvy <= mag_of(i_state.vel_y);
            r1_nx  <= i_state.pos_x[W-1];
            r1_ny  <= i_state.pos_y[W-1];
            r1_nvx <= i_state.vel_x[W-1];
            r1_nvy <= i_state.vel_y[W-1];
        end
    end

    // stages 2-3: squares and cross products
    logic [2*W-1:0] px2, py2, pvx, pvy;

    rmj_mul #(.A_BITS(W), .B_BITS(W)) u_mul_px2 (
        .i_clk(i_clk), .i_en(en), .i_a(r1_mx), .i_b(r1_mx), .o_p(px2));
    rmj_mul #(.A_BITS(W), .B_BITS(W)) u_mul_py2 (
        .i_clk(i_clk), .i_en(en), .i_a(r1_my), .i_b(r1_my), .o_p(py2));
    rmj_mul #(.A_BITS(W), .B_BITS(W)) u_mul_pvx (
        .i_clk(i_clk), .i_en(en), .i_a(r1_mvx), .i_b(r1_my), .o_p(pvx));
    rmj_mul #(.A_BITS(W), .B_BITS(W)) u_mul_pvy (
        .i_clk(i_clk), .i_en(en), .i_a(r1_mvy), .i_b(r1_mx), .o_p(pvy));

    logic [W-1:0] s3_mx, s3_my;
    logic         s3_nx, s3_ny, s3_nvx, s3_nvy;

    rmj_delay #(.WIDTH(2*W+4), .DEPTH(2)) u_dly_s3 (
        .i_clk(i_clk), .i_en(en),
        .i_d({r1_mx, r1_my, r1_nx, r1_ny, r1_nvx, r1_nvy}),
        .o_d({s3_mx, s3_my, s3_nx, s3_ny, s3_nvx, s3_nvy}));

    // stage 4: squared range and vx*py - vy*px
    logic signed [2*W+1:0] sv1, sv2;
    logic [2*W-1:0]        r4_r2;
    logic signed [2*W+1:0] r4_c;

    assign sv1 = (s3_nvx ^ s3_ny) ? -$signed({2'b00, pvx}) : $signed({2'b00, pvx});
    assign sv2 = (s3_nvy ^ s3_nx) ? -$signed({2'b00, pvy}) : $signed({2'b00, pvy});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_r2 <= px2 + py2;
            r4_c  <= sv1 - sv2;
        end
    end

    // stage 5: too-close test, |c|
    logic [2*W-1:0] r5_r2;
    logic [2*W-1:0] r5_cm;
    logic           r5_cneg;
    logic           r5_tc;
    logic [W-1:0]   s5_mx, s5_my;
    logic           s5_nx, s5_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_r2   <= r4_r2;
            r5_tc   <= (r4_r2 == '0) || (TW'(r4_r2) < TW'({r_thr, {F{1'b0}}}));
            r5_cneg <= r4_c[2*W+1];
            r5_cm   <= r4_c[2*W+1] ? (2*W)'(-r4_c) : (2*W)'(r4_c);
        end
    end

    rmj_delay #(.WIDTH(2*W+2), .DEPTH(2)) u_dly_s5 (
        .i_clk(i_clk), .i_en(en),
        .i_d({s3_mx, s3_my, s3_nx, s3_ny}),
        .o_d({s5_mx, s5_my, s5_nx, s5_ny}));

    // square-root row
    logic [W+1:0]   sq_rem  [W+1];
    logic [W-1:0]   sq_root [W+1];
    logic [2*W-1:0] sq_val  [W+1];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_val[0]  = r5_r2;

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        rmj_sqrt_cell #(.W(W)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (sq_rem[k]),
            .i_root(sq_root[k]),
            .i_val (sq_val[k]),
            .o_rem (sq_rem[k+1]),
            .o_root(sq_root[k+1]),
            .o_val (sq_val[k+1])
        );
    end

    logic [W-1:0]   root;
    logic [W-1:0]   b_mx, b_my;
    logic           b_nx, b_ny, b_cneg, b_tc;
    logic [2*W-1:0] b_cm, b_r2;

    assign root = sq_root[W];

    rmj_delay #(.WIDTH(6*W+4), .DEPTH(W)) u_dly_sq (
        .i_clk(i_clk), .i_en(en),
        .i_d({s5_mx, s5_my, s5_nx, s5_ny, r5_cm, r5_cneg, r5_tc, r5_r2}),
        .o_d({b_mx, b_my, b_nx, b_ny, b_cm, b_cneg, b_tc, b_r2}));

    // r^3 and rate numerators
    logic [2*W-1:0] rr;
    logic [W-1:0]   root_d2;
    logic [3*W-1:0] r3;
    logic [3*W-1:0] myc, mxc, myc_d, mxc_d;

    rmj_mul #(.A_BITS(W), .B_BITS(W)) u_mul_rr (
        .i_clk(i_clk), .i_en(en), .i_a(root), .i_b(root), .o_p(rr));
    rmj_delay #(.WIDTH(W), .DEPTH(2)) u_dly_root (
        .i_clk(i_clk), .i_en(en), .i_d(root), .o_d(root_d2));
    rmj_mul #(.A_BITS(2*W), .B_BITS(W)) u_mul_r3 (
        .i_clk(i_clk), .i_en(en), .i_a(rr), .i_b(root_d2), .o_p(r3));
    rmj_mul #(.A_BITS(W), .B_BITS(2*W)) u_mul_myc (
        .i_clk(i_clk), .i_en(en), .i_a(b_my), .i_b(b_cm), .o_p(myc));
    rmj_mul #(.A_BITS(W), .B_BITS(2*W)) u_mul_mxc (
        .i_clk(i_clk), .i_en(en), .i_a(b_mx), .i_b(b_cm), .o_p(mxc));
    rmj_delay #(.WIDTH(6*W), .DEPTH(2)) u_dly_mc (
        .i_clk(i_clk), .i_en(en), .i_d({myc, mxc}), .o_d({myc_d, mxc_d}));

    logic [W-1:0]   c_mx, c_my, c_root;
    logic           c_nx, c_ny, c_cneg, c_cnz, c_tc;
    logic [2*W-1:0] c_r2;

    rmj_delay #(.WIDTH(5*W+5), .DEPTH(4)) u_dly_c (
        .i_clk(i_clk), .i_en(en),
        .i_d({b_mx, b_my, b_nx, b_ny, b_cneg, (b_cm != '0), b_tc, b_r2, root}),
        .o_d({c_mx, c_my, c_nx, c_ny, c_cneg, c_cnz, c_tc, c_r2, c_root}));

    // divider rows
    logic [W-1:0] q [6];
    logic         ovf [6];

    rmj_div #(.NUM_BITS(W+F), .DEN_BITS(W), .Q_BITS(W)) u_div_rx (
        .i_clk(i_clk), .i_en(en), .i_num({c_mx, {F{1'b0}}}), .i_den(c_root),
        .o_q(q[0]), .o_ovf(ovf[0]));
    rmj_div #(.NUM_BITS(W+F), .DEN_BITS(W), .Q_BITS(W)) u_div_ry (
        .i_clk(i_clk), .i_en(en), .i_num({c_my, {F{1'b0}}}), .i_den(c_root),
        .o_q(q[1]), .o_ovf(ovf[1]));
    rmj_div #(.NUM_BITS(W+2*F), .DEN_BITS(2*W), .Q_BITS(W)) u_div_bx (
        .i_clk(i_clk), .i_en(en), .i_num({c_my, {(2*F){1'b0}}}), .i_den(c_r2),
        .o_q(q[2]), .o_ovf(ovf[2]));
    rmj_div #(.NUM_BITS(W+2*F), .DEN_BITS(2*W), .Q_BITS(W)) u_div_by (
        .i_clk(i_clk), .i_en(en), .i_num({c_mx, {(2*F){1'b0}}}), .i_den(c_r2),
        .o_q(q[3]), .o_ovf(ovf[3]));
    rmj_div #(.NUM_BITS(3*W+F), .DEN_BITS(3*W), .Q_BITS(W)) u_div_vx (
        .i_clk(i_clk), .i_en(en), .i_num({myc_d, {F{1'b0}}}), .i_den(r3),
        .o_q(q[4]), .o_ovf(ovf[4]));
    rmj_div #(.NUM_BITS(3*W+F), .DEN_BITS(3*W), .Q_BITS(W)) u_div_vy (
        .i_clk(i_clk), .i_en(en), .i_num({mxc_d, {F{1'b0}}}), .i_den(r3),
        .o_q(q[5]), .o_ovf(ovf[5]));

    logic [5:0] c_neg;
    logic [5:0] d_neg;
    logic       d_tc;

    assign c_neg[0] = c_nx;
    assign c_neg[1] = c_ny;
    assign c_neg[2] = !c_ny && (c_my != '0);
    assign c_neg[3] = c_nx;
    assign c_neg[4] = (c_ny != c_cneg) && (c_my != '0) && c_cnz;
    assign c_neg[5] = (c_nx == c_cneg) && (c_mx != '0) && c_cnz;

    rmj_delay #(.WIDTH(7), .DEPTH(W+1)) u_dly_neg (
        .i_clk(i_clk), .i_en(en), .i_d({c_neg, c_tc}), .o_d({d_neg, d_tc}));

    // output register
    logic [W-1:0] r_ent [6];
    logic         r_tc;

    always_ff @(posedge i_clk) begin
        if (out_load && r_vld[P]) begin
            for (int k = 0; k < 6; k++) begin
                r_ent[k] <= d_tc ? '0 : finish(q[k], ovf[k], d_neg[k]);
            end
            r_tc <= d_tc;
        end
    end

    assign o_jac.valid      = r_ov;
    assign o_jac.range_dx   = r_ent[0];
    assign o_jac.range_dy   = r_ent[1];
    assign o_jac.bearing_dx = r_ent[2];
    assign o_jac.bearing_dy = r_ent[3];
    assign o_jac.rate_dx    = r_ent[4];
    assign o_jac.rate_dy    = r_ent[5];
    assign o_jac.too_close  = r_tc;

    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_jac.valid && o_jac.too_close |->
            o_jac.range_dx == '0 && o_jac.range_dy == '0 && o_jac.bearing_dx == '0 &&
            o_jac.bearing_dy == '0 && o_jac.rate_dx == '0 && o_jac.rate_dy == '0)
        else $error("too_close beat with nonzero entry");

    a_hold_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_state.ready |-> o_jac.valid && !o_jac.ready && r_vld[P])
        else $error("input held without a full output side");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid |=> r_thr == $past(i_cfg.zero_threshold))
        else $error("threshold write lost");

endmodule

>>> src/rmj_mul.sv
module rmj_mul import rmj_pkg::*; #(
    parameter int A_BITS = 32,
    parameter int B_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [A_BITS-1:0]        i_a,
    input  logic [B_BITS-1:0]        i_b,
    output logic [A_BITS+B_BITS-1:0] o_p
);

    localparam int NA = (A_BITS + MUL_LIMB - 1) / MUL_LIMB;
    localparam int NB = (B_BITS + MUL_LIMB - 1) / MUL_LIMB;
    localparam int PW = A_BITS + B_BITS;

    logic [NA*MUL_LIMB-1:0] a_x;
    logic [NB*MUL_LIMB-1:0] b_x;
    logic [2*MUL_LIMB-1:0]  r_pp [NA*NB];
    logic [PW-1:0]          n_p;
    logic [PW-1:0]          r_p;

    assign a_x = (NA*MUL_LIMB)'(i_a);
    assign b_x = (NB*MUL_LIMB)'(i_b);

    // partial products registered first, then summed into the product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= a_x[i*MUL_LIMB +: MUL_LIMB] * b_x[j*MUL_LIMB +: MUL_LIMB];
                end
            end
            r_p <= n_p;
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_p = n_p + (PW'(r_pp[i*NB+j]) << ((i + j) * MUL_LIMB));
            end
        end
    end

    assign o_p = r_p;

endmodule

>>> src/rmj_delay.sv
module rmj_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_sh [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_d = r_sh[DEPTH-1];

endmodule

>>> src/rmj_sqrt_cell.sv
module rmj_sqrt_cell #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W+1:0]   i_rem,
    input  logic [W-1:0]   i_root,
    input  logic [2*W-1:0] i_val,
    output logic [W+1:0]   o_rem,
    output logic [W-1:0]   o_root,
    output logic [2*W-1:0] o_val
);

    logic [W+3:0]   sh;
    logic [W+3:0]   trial;
    logic           ge;
    logic [W+1:0]   n_rem;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [2*W-1:0] r_val;

    // one root bit per cell, two radicand bits in
    assign sh    = {i_rem, i_val[2*W-1 -: 2]};
    assign trial = (W+4)'({i_root, 2'b01});
    assign ge    = (sh >= trial);
    assign n_rem = ge ? (W+2)'(sh - trial) : (W+2)'(sh);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= {i_root[W-2:0], ge};
            r_val  <= {i_val[2*W-3:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_val  = r_val;

endmodule

>>> src/rmj_div_cell.sv
module rmj_div_cell #(
    parameter int DEN_BITS = 32,
    parameter int Q_BITS   = 32
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [DEN_BITS-1:0] i_rem,
    input  logic [DEN_BITS-1:0] i_den,
    input  logic [Q_BITS-1:0]   i_lo,
    input  logic [Q_BITS-1:0]   i_q,
    input  logic                i_ovf,
    output logic [DEN_BITS-1:0] o_rem,
    output logic [DEN_BITS-1:0] o_den,
    output logic [Q_BITS-1:0]   o_lo,
    output logic [Q_BITS-1:0]   o_q,
    output logic                o_ovf
);

    logic [DEN_BITS:0]   sh;
    logic                ge;
    logic [DEN_BITS-1:0] n_rem;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [Q_BITS-1:0]   r_lo;
    logic [Q_BITS-1:0]   r_q;
    logic                r_ovf;

    assign sh    = {i_rem, i_lo[Q_BITS-1]};
    assign ge    = (sh >= {1'b0, i_den});
    assign n_rem = ge ? DEN_BITS'(sh - {1'b0, i_den}) : DEN_BITS'(sh);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_lo  <= {i_lo[Q_BITS-2:0], 1'b0};
            r_q   <= {i_q[Q_BITS-2:0], ge};
            r_ovf <= i_ovf;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_lo  = r_lo;
    assign o_q   = r_q;
    assign o_ovf = r_ovf;

endmodule

>>> src/rmj_div.sv
module rmj_div #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 32,
    parameter int Q_BITS   = 32
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [Q_BITS-1:0]   o_q,
    output logic                o_ovf
);

    localparam int HB = NUM_BITS - Q_BITS;
    localparam int CW = (HB > DEN_BITS) ? HB : DEN_BITS;

    logic [DEN_BITS-1:0] rem_c [Q_BITS+1];
    logic [DEN_BITS-1:0] den_c [Q_BITS+1];
    logic [Q_BITS-1:0]   lo_c  [Q_BITS+1];
    logic [Q_BITS-1:0]   q_c   [Q_BITS+1];
    logic                ovf_c [Q_BITS+1];
    logic [CW-1:0]       hi;

    assign hi = CW'(i_num >> Q_BITS);

    // quotient of more than Q_BITS bits flags overflow up front
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rem_c[0] <= DEN_BITS'(i_num >> Q_BITS);
            den_c[0] <= i_den;
            lo_c[0]  <= i_num[Q_BITS-1:0];
            q_c[0]   <= '0;
            ovf_c[0] <= (hi >= CW'(i_den));
        end
    end

    for (genvar k = 0; k < Q_BITS; k++) begin : g_cell
        rmj_div_cell #(
            .DEN_BITS(DEN_BITS),
            .Q_BITS  (Q_BITS)
        ) u_cell (
            .i_clk(i_clk),
            .i_en (i_en),
            .i_rem(rem_c[k]),
            .i_den(den_c[k]),
            .i_lo (lo_c[k]),
            .i_q  (q_c[k]),
            .i_ovf(ovf_c[k]),
            .o_rem(rem_c[k+1]),
            .o_den(den_c[k+1]),
            .o_lo (lo_c[k+1]),
            .o_q  (q_c[k+1]),
            .o_ovf(ovf_c[k+1])
        );
    end

    assign o_q   = q_c[Q_BITS];
    assign o_ovf = ovf_c[Q_BITS];

endmodule
